### design/hcb_pkg.sv
// Shared constants and types of the Huffman code builder.
package hcb_pkg;

    localparam int SYMBOLS     = 32;
    localparam int IDX_W       = $clog2(SYMBOLS);
    localparam int NODE_W      = IDX_W + 1;
    localparam int SYM_W       = 8;
    localparam int IN_W_W      = 16;
    localparam int WGT_W       = 21;
    localparam int CODE_W      = 31;
    localparam int LEN_W       = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 48;

    // One loaded entry as handed from the front end to the builder
    typedef struct packed {
        logic              store;
        logic              last;
        logic [SYM_W-1:0]  sym;
        logic [IN_W_W-1:0] weight;
    } hcb_entry_t;

endpackage

### design/hcb_front.sv
// Input side: accept entries, mark them kept or dropped, and queue them.
module hcb_front
    import hcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SYM_W-1:0]     in_sym,
    input  logic [IN_W_W-1:0]    in_weight,
    input  logic                 in_last,
    output logic                 q_valid,
    output hcb_entry_t           q_entry,
    input  logic                 q_pop
);

    hcb_entry_t                queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]           fill_reg, fill_next;
    logic [NODE_W-1:0]         cnt_reg, cnt_next;
    logic                      push;
    logic                      keep;
    logic                      pop;

    assign in_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = in_valid & in_ready;
    assign pop      = q_pop & q_valid;
    assign keep     = (cnt_reg != NODE_W'(SYMBOLS));
    assign q_valid  = (fill_reg != '0);
    assign q_entry  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        cnt_next    = cnt_reg;
        if (push)
        begin
            // restart the count after the entry that closes a set
            if (in_last)
                cnt_next = '0;
            else if (keep)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{store: keep, last: in_last,
                                       sym: in_sym, weight: in_weight};
        end
    end

endmodule

### design/hcb_back.sv
// Builder: hold the entries, merge the two lightest nodes, walk the tree.
module hcb_back
    import hcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  hcb_entry_t           q_entry,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SYM_W-1:0]     out_sym,
    output logic [CODE_W-1:0]    out_code,
    output logic [LEN_W-1:0]     out_len,
    output logic                 out_last
);

    typedef enum logic [3:0] {
        B_LOAD  = 4'b0001,
        B_SCAN  = 4'b0010,
        B_MERGE = 4'b0100,
        B_WALK  = 4'b1000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [NODE_W-1:0]    cnt_reg, cnt_next;
    logic [NODE_W-1:0]    n_reg, n_next;
    logic [NODE_W-1:0]    size_reg, size_next;
    logic [NODE_W-1:0]    nxt_reg, nxt_next;
    logic [NODE_W-1:0]    sp_reg, sp_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic [IDX_W-1:0]     m1_reg, m1_next;
    logic [IDX_W-1:0]     m2_reg, m2_next;
    logic                 m2v_reg, m2v_next;
    logic [WGT_W-1:0]     w1_reg, w1_next;
    logic [WGT_W-1:0]     w2_reg, w2_next;
    logic                 ov_reg, ov_next;

    logic [SYM_W-1:0]     sym_reg [SYMBOLS];
    logic [WGT_W-1:0]     aw_reg  [SYMBOLS];
    logic [NODE_W-1:0]    ai_reg  [SYMBOLS];
    logic [NODE_W-1:0]    lc_reg  [SYMBOLS];
    logic [NODE_W-1:0]    rc_reg  [SYMBOLS];
    logic [NODE_W-1:0]    sn_reg  [SYMBOLS];
    logic [CODE_W-1:0]    sc_reg  [SYMBOLS];
    logic [LEN_W-1:0]     sl_reg  [SYMBOLS];

    logic [SYM_W-1:0]     osym_reg;
    logic [CODE_W-1:0]    ocode_reg;
    logic [LEN_W-1:0]     olen_reg;
    logic                 olast_reg;

    logic [NODE_W-1:0]    cnt_after;
    logic [WGT_W-1:0]     scan_w;
    logic [WGT_W-1:0]     sum;
    logic [IDX_W-1:0]     top;
    logic [NODE_W-1:0]    tn;
    logic [CODE_W-1:0]    tc;
    logic [LEN_W-1:0]     tl;
    logic                 is_leaf;
    logic                 can_emit;
    logic                 emit;
    logic                 expand;
    logic [IDX_W-1:0]     k_walk;
    logic [IDX_W-1:0]     k_merge;
    logic                 root_set;
    logic [NODE_W-1:0]    root_node;

    assign q_pop     = (state_reg == B_LOAD);
    assign cnt_after = cnt_reg + NODE_W'(q_entry.store);
    assign scan_w    = aw_reg[i_reg];
    assign sum       = w1_reg + w2_reg;
    assign top       = IDX_W'(sp_reg - 1'b1);
    assign tn        = sn_reg[top];
    assign tc        = sc_reg[top];
    assign tl        = sl_reg[top];
    assign is_leaf   = (tn < n_reg);
    assign can_emit  = !ov_reg || out_ready;
    assign emit      = (state_reg == B_WALK) && (sp_reg != '0) && is_leaf && can_emit;
    assign expand    = (state_reg == B_WALK) && (sp_reg != '0) && !is_leaf;
    assign k_walk    = IDX_W'(tn - n_reg);
    assign k_merge   = IDX_W'(nxt_reg - n_reg);

    assign out_valid = ov_reg;
    assign out_sym   = osym_reg;
    assign out_code  = ocode_reg;
    assign out_len   = olen_reg;
    assign out_last  = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        size_next  = size_reg;
        nxt_next   = nxt_reg;
        sp_next    = sp_reg;
        i_next     = i_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        m2v_next   = m2v_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        ov_next    = (ov_reg && !out_ready) || emit;
        root_set   = 1'b0;
        root_node  = '0;
        case (state_reg)
            B_LOAD:
            begin
                if (q_valid)
                begin
                    cnt_next = cnt_after;
                    if (q_entry.last && (cnt_after != '0))
                    begin
                        cnt_next  = '0;
                        n_next    = cnt_after;
                        size_next = cnt_after;
                        nxt_next  = cnt_after;
                        i_next    = '0;
                        if (cnt_after == NODE_W'(1))
                        begin
                            state_next = B_WALK;
                            root_set   = 1'b1;
                            sp_next    = NODE_W'(1);
                        end
                        else
                        begin
                            state_next = B_SCAN;
                        end
                    end
                end
            end
            B_SCAN:
            begin
                if (i_reg == '0)
                begin
                    m1_next  = '0;
                    w1_next  = scan_w;
                    m2v_next = 1'b0;
                end
                else if (scan_w < w1_reg)
                begin
                    m2_next  = m1_reg;
                    w2_next  = w1_reg;
                    m2v_next = 1'b1;
                    m1_next  = i_reg;
                    w1_next  = scan_w;
                end
                else if (!m2v_reg || (scan_w < w2_reg))
                begin
                    m2_next  = i_reg;
                    w2_next  = scan_w;
                    m2v_next = 1'b1;
                end
                i_next = i_reg + 1'b1;
                if ({1'b0, i_reg} == size_reg - 1'b1)
                    state_next = B_MERGE;
            end
            B_MERGE:
            begin
                size_next = size_reg - 1'b1;
                nxt_next  = nxt_reg + 1'b1;
                i_next    = '0;
                if (size_reg == NODE_W'(2))
                begin
                    // the last merged node is the root
                    state_next = B_WALK;
                    root_set   = 1'b1;
                    root_node  = nxt_reg;
                    sp_next    = NODE_W'(1);
                end
                else
                begin
                    state_next = B_SCAN;
                end
            end
            B_WALK:
            begin
                if (emit)
                begin
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == NODE_W'(1))
                        state_next = B_LOAD;
                end
                else if (expand)
                begin
                    sp_next = sp_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = B_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            cnt_reg   <= '0;
            n_reg     <= '0;
            size_reg  <= '0;
            nxt_reg   <= '0;
            sp_reg    <= '0;
            i_reg     <= '0;
            m1_reg    <= '0;
            m2_reg    <= '0;
            m2v_reg   <= 1'b0;
            w1_reg    <= '0;
            w2_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            size_reg  <= size_next;
            nxt_reg   <= nxt_next;
            sp_reg    <= sp_next;
            i_reg     <= i_next;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            m2v_reg   <= m2v_next;
            w1_reg    <= w1_next;
            w2_reg    <= w2_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload storage: entries, active list, children, walk stack, result
    always_ff @(posedge clk)
    begin
        if ((state_reg == B_LOAD) && q_valid && q_entry.store)
        begin
            sym_reg[cnt_reg[IDX_W-1:0]] <= q_entry.sym;
            aw_reg[cnt_reg[IDX_W-1:0]]  <= WGT_W'(q_entry.weight);
            ai_reg[cnt_reg[IDX_W-1:0]]  <= cnt_reg;
        end
        if (state_reg == B_MERGE)
        begin
            lc_reg[k_merge] <= ai_reg[m1_reg];
            rc_reg[k_merge] <= ai_reg[m2_reg];
            // put the merged node in the first slot and close up the second
            for (int j = 0; j < SYMBOLS; j++)
            begin
                if ((IDX_W'(j) >= m2_reg) && (j < SYMBOLS - 1))
                begin
                    if (IDX_W'(j + 1) == m1_reg)
                    begin
                        aw_reg[j] <= sum;
                        ai_reg[j] <= nxt_reg;
                    end
                    else
                    begin
                        aw_reg[j] <= aw_reg[j + 1];
                        ai_reg[j] <= ai_reg[j + 1];
                    end
                end
                else if (IDX_W'(j) == m1_reg)
                begin
                    aw_reg[j] <= sum;
                    ai_reg[j] <= nxt_reg;
                end
            end
        end
        if (root_set)
        begin
            sn_reg[0] <= root_node;
            sc_reg[0] <= '0;
            sl_reg[0] <= '0;
        end
        if (expand)
        begin
            sn_reg[top] <= rc_reg[k_walk];
            sc_reg[top] <= {tc[CODE_W-2:0], 1'b1};
            sl_reg[top] <= tl + 1'b1;
            sn_reg[sp_reg[IDX_W-1:0]] <= lc_reg[k_walk];
            sc_reg[sp_reg[IDX_W-1:0]] <= {tc[CODE_W-2:0], 1'b0};
            sl_reg[sp_reg[IDX_W-1:0]] <= tl + 1'b1;
        end
        if (emit)
        begin
            osym_reg  <= sym_reg[tn[IDX_W-1:0]];
            ocode_reg <= tc;
            olen_reg  <= tl;
            olast_reg <= (sp_reg == NODE_W'(1));
        end
    end

endmodule

### design/huffman_code_builder.sv
// Top level of the Huffman code builder.
//
// Input channel s_axis: one (symbol, weight) entry per transfer, tlast on the
// entry that closes a set. Entries enter a four-deep queue at one per cycle
// while it has room, and are stored at one per cycle while the builder loads.
// Up to 32 entries are kept; further entries of a set are dropped, although
// a dropped entry carrying tlast still starts the build over the entries held.
// Output channel m_axis: one code per leaf in preorder of the tree, tlast on
// the last code of the set.
// Build: for each merge the single compare unit scans the active list and
// the merge state joins the two lightest nodes; the tree walk then moves
// one stack step per cycle, except while a leaf waits on a stalled receiver,
// and each code goes to the output register.
// Throughput: one set at a time; the queue keeps taking entries of the next
// set while a build or walk runs, until it is full.
// A stalled receiver holds the walk at the next leaf; the result waits in
// the output register unchanged.
// Reset clears the queue, the counts and the output valid; stored entries
// need no clearing since every set writes them before they are read.
module huffman_code_builder
    import hcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // symbol[7:0], weight[23:8]
    input  logic                  s_axis_tlast,   // final_entry
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // leaf_symbol[7:0],
                                                  // code_bits[38:8],
                                                  // code_length[43:39], zero
    output logic                  m_axis_tlast    // final_code
);

    logic                 q_valid;
    hcb_entry_t           q_entry;
    logic                 q_pop;
    logic [SYM_W-1:0]     out_sym;
    logic [CODE_W-1:0]    out_code;
    logic [LEN_W-1:0]     out_len;

    // Front end: take each transfer and tag it kept or dropped
    hcb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sym    (s_axis_tdata[SYM_W-1:0]),
        .in_weight (s_axis_tdata[SYM_W+IN_W_W-1:SYM_W]),
        .in_last   (s_axis_tlast),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop)
    );

    // Back end: store, merge, walk and present codes
    hcb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_sym   (out_sym),
        .out_code  (out_code),
        .out_len   (out_len),
        .out_last  (m_axis_tlast)
    );

    // Pack the result fields from the lowest bit up, zero padding on top
    assign m_axis_tdata = {(OUT_DATA_W-SYM_W-CODE_W-LEN_W)'(0), out_len, out_code, out_sym};

endmodule

### design/hcb_checker.sv
// Port checker of the Huffman code builder and its binding.
module hcb_checker
    import hcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A waiting entry holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("waiting entry changed");

    // No code bits above the code length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[38:8] >> m_axis_tdata[43:39]) == '0))
        else $error("code bits beyond code length");

    // Padding stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:44] == '0))
        else $error("padding bits set");

    // No result during reset
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result shown in reset");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
